// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");

// The consequent must hold at a later cycle than the antecedent.
`define CHK_TWO(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> ##2 (cons)) \
    else $error("check failed");

`endif

// ===== rtl/mlfq_pkg.sv =====
// Shared constants, types and helpers of the feedback queue scheduler.
package mlfq_pkg;

  localparam int ID_W        = 6;
  localparam int DATA_W      = 32;
  localparam int BOOST_W     = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int LVL_FIELD_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_SLICE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOST  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELOAD = 2'd2;

  // Operation codes.
  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  // Queue command from the sequencer to the queue controller.
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [LVL_FIELD_W-1:0] push_lvl;
    logic [LVL_FIELD_W-1:0] pop_lvl;
    logic [ID_W-1:0]        push_id;
  } q_cmd_t;

  // Saturating 32-bit add.
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/mlfq_tmem.sv =====
// Task memory holding each task's level and run time, with a clearing sweep after reset.
module mlfq_tmem #(
  parameter int NUM_TASKS = 64,
  parameter int ENTRY_W   = 34
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_TASKS)-1:0] rd_addr,
  output logic [ENTRY_W-1:0]           rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_TASKS)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]           wr_data,
  output logic                         clearing
);
  localparam int TW = $clog2(NUM_TASKS);
  localparam logic [TW-1:0] LAST_ADDR = TW'(NUM_TASKS - 1);

  logic [ENTRY_W-1:0] mem [NUM_TASKS];
  logic [TW-1:0]      clr_idx;

  // Sweep counter that walks every entry once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + TW'(1);
      end
    end
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mlfq_qctl.sv =====
// Per-level circular queues: pointer registers and the shared slot memory.
module mlfq_qctl #(
  parameter int NUM_TASKS  = 64,
  parameter int NUM_LEVELS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mlfq_pkg::q_cmd_t          cmd,
  output logic [mlfq_pkg::ID_W-1:0] pop_id,
  output logic [NUM_LEVELS-1:0]     empty
);
  import mlfq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam logic [TW-1:0] LAST_SLOT = TW'(NUM_TASKS - 1);

  logic [TW-1:0]   head [NUM_LEVELS];
  logic [TW-1:0]   tail [NUM_LEVELS];
  logic [ID_W-1:0] slots [NUM_LEVELS][NUM_TASKS];

  logic [LW-1:0] plvl;
  logic [LW-1:0] qlvl;
  logic [TW-1:0] tail_inc;
  logic [TW-1:0] wr_idx;
  logic          wr_en;

  function automatic logic [TW-1:0] ring_inc(input logic [TW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + TW'(1);
  endfunction

  // Work out where a push lands; a push into a full queue is dropped.
  always_comb begin
    plvl     = LW'(cmd.push_lvl);
    qlvl     = LW'(cmd.pop_lvl);
    tail_inc = ring_inc(tail[plvl]);
    wr_en    = 1'b0;
    wr_idx   = '0;
    if (cmd.push) begin
      if (empty[plvl]) begin
        wr_en = 1'b1;
      end else if (tail_inc != head[plvl]) begin
        wr_en  = 1'b1;
        wr_idx = tail_inc;
      end
    end
  end

  // Head, tail and empty flags of every level.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
      end
      empty <= '1;
    end else begin
      if (wr_en) begin
        tail[plvl] <= wr_idx;
        if (empty[plvl]) begin
          head[plvl]  <= '0;
          empty[plvl] <= 1'b0;
        end
      end
      if (cmd.pop) begin
        if (head[qlvl] == tail[qlvl]) begin
          empty[qlvl] <= 1'b1;
        end else begin
          head[qlvl] <= ring_inc(head[qlvl]);
        end
      end
    end
  end

  // Slot memory: one write, one registered read at the popped head.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[plvl][wr_idx] <= cmd.push_id;
    end
    if (cmd.pop) begin
      pop_id <= slots[qlvl][head[qlvl]];
    end
  end

endmodule

// ===== rtl/mlfq_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler: sequencer and registers.
//
//  Channel   | Signals                                           | Handshake
//  ----------+---------------------------------------------------+-------------------------
//  command   | op, task_id, has_current, requeue_current,        | start high, busy low
//            | timer_now                                         |
//  result    | chosen_task, chosen_valid                         | done strobe, one cycle
//  config    | cfg_addr, cfg_wdata                               | cfg_wr high
//
// An admit passes only through the admit state. A schedule runs elapsed-time, charge and
// demote steps for a valid current task, a boost check, on a priority boost a walk moving
// tasks of levels 1 and up to level 0, and dispatch; this walk through the slot and task
// memories sets the worst case. After reset the task memory is cleared one entry per
// cycle, with busy high. One transaction is in flight at a time; the result cannot be
// stalled and a new command may be accepted in the cycle done is shown.
module mlfq_scheduler #(
  parameter int NUM_TASKS  = 64,
  parameter int NUM_LEVELS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [mlfq_pkg::ID_W-1:0]       task_id,
  input  logic                            has_current,
  input  logic                            requeue_current,
  input  logic [mlfq_pkg::DATA_W-1:0]     timer_now,
  output logic                            done,
  output logic [mlfq_pkg::ID_W-1:0]       chosen_task,
  output logic                            chosen_valid,
  input  logic                            cfg_wr,
  input  logic [mlfq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mlfq_pkg::DATA_W-1:0]     cfg_wdata
);
  import mlfq_pkg::*;

  localparam int TW     = $clog2(NUM_TASKS);
  localparam int LW     = $clog2(NUM_LEVELS);
  localparam int EW     = LW + DATA_W;
  localparam int LIM_W  = DATA_W + NUM_LEVELS;
  localparam int PROD_W = DATA_W + BOOST_W;
  localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADMIT, ST_EL1, ST_EL2, ST_CHG, ST_DEM, ST_BCHK,
    ST_BPOP, ST_BTSK, ST_BWR, ST_DPOP, ST_DOUT
  } state_t;

  state_t state;

  // Configuration registers and the boost threshold product.
  logic [DATA_W-1:0]  slice_length;
  logic [BOOST_W-1:0] boost_slices;
  logic [DATA_W-1:0]  timer_reload;
  logic [PROD_W-1:0]  boost_limit;

  // Latched command.
  logic [ID_W-1:0]   tid_r;
  logic              has_r;
  logic              req_r;
  logic [DATA_W-1:0] now_r;

  // Working registers.
  logic [DATA_W-1:0] time_since_boost;
  logic [DATA_W-1:0] last_timer_value;
  logic              last_gt;
  logic [DATA_W-1:0] diff_down;
  logic [DATA_W-1:0] diff_up;
  logic [DATA_W-1:0] elapsed;
  logic [DATA_W-1:0] run_sum;
  logic [LW-1:0]     lvl_r;
  logic [LW-1:0]     blvl;
  logic [ID_W-1:0]   bt;

  // Memory and queue connections.
  q_cmd_t          qcmd;
  logic [ID_W-1:0] pop_id;
  logic [NUM_LEVELS-1:0] q_empty;
  logic            t_rd_en;
  logic [TW-1:0]   t_rd_addr;
  logic [EW-1:0]   t_rd_data;
  logic            t_wr_en;
  logic [TW-1:0]   t_wr_addr;
  logic [EW-1:0]   t_wr_data;
  logic            clearing;

  // Derived control values.
  logic             in_range;
  logic             cur_ok;
  logic [TW-1:0]    tidx;
  logic [LIM_W-1:0] limit;
  logic             demote;
  logic [LW-1:0]    new_lvl;
  logic             do_boost;
  logic             any_ready;
  logic [LW-1:0]    dlvl;

  assign busy = (state != ST_IDLE) || clearing;

  // Task checks, demotion and boost decisions.
  always_comb begin
    in_range = DATA_W'(tid_r) < DATA_W'(NUM_TASKS);
    cur_ok   = has_r && in_range;
    tidx     = TW'(tid_r);
    limit    = LIM_W'(slice_length) << lvl_r;
    demote   = LIM_W'(run_sum) >= limit;
    new_lvl  = (demote && (lvl_r != TOP_LVL)) ? lvl_r + LW'(1) : lvl_r;
    do_boost = (time_since_boost >= slice_length) &&
               (PROD_W'(time_since_boost) >= boost_limit);
  end

  // Non-empty level with the lowest number, which is the highest priority.
  always_comb begin
    dlvl      = '0;
    any_ready = ~&q_empty;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (!q_empty[l]) begin
        dlvl = LW'(l);
      end
    end
  end

  // Queue commands and task memory accesses per state.
  always_comb begin
    qcmd      = '0;
    t_rd_en   = 1'b0;
    t_rd_addr = tidx;
    t_wr_en   = 1'b0;
    t_wr_addr = tidx;
    t_wr_data = '0;
    case (state)
      ST_ADMIT: begin
        if (in_range) begin
          qcmd.push    = 1'b1;
          qcmd.push_id = tid_r;
          t_wr_en      = 1'b1;
        end
      end
      ST_EL2: begin
        t_rd_en = 1'b1;
      end
      ST_DEM: begin
        t_wr_en   = 1'b1;
        t_wr_data = {new_lvl, demote ? {DATA_W{1'b0}} : run_sum};
        if (req_r) begin
          qcmd.push     = 1'b1;
          qcmd.push_lvl = LVL_FIELD_W'(new_lvl);
          qcmd.push_id  = tid_r;
        end
      end
      ST_BPOP: begin
        if (!q_empty[blvl]) begin
          qcmd.pop     = 1'b1;
          qcmd.pop_lvl = LVL_FIELD_W'(blvl);
        end
      end
      ST_BTSK: begin
        t_rd_en   = 1'b1;
        t_rd_addr = TW'(pop_id);
      end
      ST_BWR: begin
        qcmd.push    = 1'b1;
        qcmd.push_id = bt;
        t_wr_en      = 1'b1;
        t_wr_addr    = TW'(bt);
        t_wr_data    = {LW'(0), t_rd_data[DATA_W-1:0]};
      end
      ST_DPOP: begin
        if (any_ready) begin
          qcmd.pop     = 1'b1;
          qcmd.pop_lvl = LVL_FIELD_W'(dlvl);
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; the boost threshold is registered behind the multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= DATA_W'(1000000);
      boost_slices <= BOOST_W'(10);
      timer_reload <= DATA_W'(10000000);
    end else if (cfg_wr) begin
      case (cfg_addr)
        CFG_SLICE:  slice_length <= cfg_wdata;
        CFG_BOOST:  boost_slices <= cfg_wdata[BOOST_W-1:0];
        CFG_RELOAD: timer_reload <= cfg_wdata;
        default: begin
        end
      endcase
    end
    boost_limit <= PROD_W'(slice_length) * PROD_W'(boost_slices);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      done             <= 1'b0;
      chosen_task      <= '0;
      chosen_valid     <= 1'b0;
      time_since_boost <= '0;
      last_timer_value <= '0;
      blvl             <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start && !busy) begin
            tid_r <= task_id;
            has_r <= has_current;
            req_r <= requeue_current;
            now_r <= timer_now;
            state <= (op == OP_ADMIT) ? ST_ADMIT : ST_EL1;
          end
        end
        ST_ADMIT: begin
          done         <= 1'b1;
          chosen_task  <= '0;
          chosen_valid <= 1'b0;
          state        <= ST_IDLE;
        end
        ST_EL1: begin
          last_gt   <= last_timer_value > now_r;
          diff_down <= last_timer_value - now_r;
          diff_up   <= now_r - last_timer_value;
          state     <= cur_ok ? ST_EL2 : ST_BCHK;
        end
        ST_EL2: begin
          if (last_gt) begin
            elapsed <= diff_down;
          end else if (diff_up > timer_reload) begin
            elapsed <= '0;
          end else begin
            elapsed <= timer_reload - diff_up;
          end
          state <= ST_CHG;
        end
        ST_CHG: begin
          lvl_r            <= t_rd_data[EW-1:DATA_W];
          run_sum          <= sat_add(t_rd_data[DATA_W-1:0], elapsed);
          time_since_boost <= sat_add(time_since_boost, elapsed);
          state            <= ST_DEM;
        end
        ST_DEM: begin
          state <= ST_BCHK;
        end
        ST_BCHK: begin
          blvl  <= LW'(1);
          state <= do_boost ? ST_BPOP : ST_DPOP;
        end
        ST_BPOP: begin
          if (q_empty[blvl]) begin
            if (blvl == TOP_LVL) begin
              time_since_boost <= '0;
              state            <= ST_DPOP;
            end else begin
              blvl <= blvl + LW'(1);
            end
          end else begin
            state <= ST_BTSK;
          end
        end
        ST_BTSK: begin
          bt    <= pop_id;
          state <= ST_BWR;
        end
        ST_BWR: begin
          state <= ST_BPOP;
        end
        ST_DPOP: begin
          if (any_ready) begin
            state <= ST_DOUT;
          end else begin
            done         <= 1'b1;
            chosen_task  <= '0;
            chosen_valid <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        ST_DOUT: begin
          done             <= 1'b1;
          chosen_task      <= pop_id;
          chosen_valid     <= 1'b1;
          last_timer_value <= now_r;
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mlfq_qctl #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_qctl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (qcmd),
    .pop_id (pop_id),
    .empty  (q_empty)
  );

  mlfq_tmem #(
    .NUM_TASKS (NUM_TASKS),
    .ENTRY_W   (EW)
  ) u_tmem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (t_rd_en),
    .rd_addr  (t_rd_addr),
    .rd_data  (t_rd_data),
    .wr_en    (t_wr_en),
    .wr_addr  (t_wr_addr),
    .wr_data  (t_wr_data),
    .clearing (clearing)
  );

endmodule

// ===== rtl/mlfq_checker.sv =====
// Port-level checker of the scheduler and its bind statement.
`include "assert_macros.svh"

module mlfq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            op,
  input logic                            done,
  input logic [mlfq_pkg::ID_W-1:0]       chosen_task,
  input logic                            chosen_valid
);
  import mlfq_pkg::*;

  // A result shows only when the block has gone back to idle.
  `CHK_SAME(a_done_idle, clk, rst, done, !busy)
  // An accepted transaction makes the block busy in the next cycle.
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Results never come in two adjacent cycles.
  `CHK_NEXT(a_done_single, clk, rst, done, !done)
  // No dispatch means a zero task number.
  `CHK_SAME(a_none_zero, clk, rst, done && !chosen_valid, chosen_task == '0)
  // An admit answers once it has passed through the admit state, with no dispatch.
  `CHK_TWO(a_admit_time, clk, rst, start && !busy && (op == OP_ADMIT), done && !chosen_valid)

endmodule

bind mlfq_scheduler mlfq_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .done         (done),
  .chosen_task  (chosen_task),
  .chosen_valid (chosen_valid)
);
